>>> design/mck_pkg.sv
// shared types, constants and the character table of the morse keyer
package mck_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CHAR_W  = 8;
   localparam int UNITS_W = 4;
   localparam int DUR_W   = 5;
   localparam int ELEM_W  = 3;
   localparam int PAT_W   = 6;
   localparam int CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DOT          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_GAP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_EXTRA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_GAP     = 3'd4;

   localparam logic [UNITS_W-1:0] DOT_RESET          = 4'd1;
   localparam logic [UNITS_W-1:0] DASH_RESET         = 4'd3;
   localparam logic [UNITS_W-1:0] ELEMENT_GAP_RESET  = 4'd1;
   localparam logic [UNITS_W-1:0] LETTER_EXTRA_RESET = 4'd2;
   localparam logic [UNITS_W-1:0] WORD_GAP_RESET     = 4'd6;

   // classified character: element count (0 = no code) and dash flags,
   // first element in the top bit
   typedef struct packed {
      logic [ELEM_W-1:0] len;
      logic [PAT_W-1:0]  dash;
   } mck_class_type;

   typedef struct packed {
      logic [UNITS_W-1:0] dot;
      logic [UNITS_W-1:0] dash;
      logic [UNITS_W-1:0] element_gap;
      logic [UNITS_W-1:0] letter_extra;
      logic [UNITS_W-1:0] word_gap;
   } mck_cfg_type;

   function automatic mck_class_type mck_classify(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] c;
      mck_class_type     r;
      c = ch;
      if (c >= "a" && c <= "z") begin
         c = c - 8'd32;
      end
      case (c)
         "A": r = '{3'd2, 6'b010000};
         "B": r = '{3'd4, 6'b100000};
         "C": r = '{3'd4, 6'b101000};
         "D": r = '{3'd3, 6'b100000};
         "E": r = '{3'd1, 6'b000000};
         "F": r = '{3'd4, 6'b001000};
         "G": r = '{3'd3, 6'b110000};
         "H": r = '{3'd4, 6'b000000};
         "I": r = '{3'd2, 6'b000000};
         "J": r = '{3'd4, 6'b011100};
         "K": r = '{3'd3, 6'b101000};
         "L": r = '{3'd4, 6'b010000};
         "M": r = '{3'd2, 6'b110000};
         "N": r = '{3'd2, 6'b100000};
         "O": r = '{3'd3, 6'b111000};
         "P": r = '{3'd4, 6'b011000};
         "Q": r = '{3'd4, 6'b110100};
         "R": r = '{3'd3, 6'b010000};
         "S": r = '{3'd3, 6'b000000};
         "T": r = '{3'd1, 6'b100000};
         "U": r = '{3'd3, 6'b001000};
         "V": r = '{3'd4, 6'b000100};
         "W": r = '{3'd3, 6'b011000};
         "X": r = '{3'd4, 6'b100100};
         "Y": r = '{3'd4, 6'b101100};
         "Z": r = '{3'd4, 6'b110000};
         "0": r = '{3'd5, 6'b111110};
         "1": r = '{3'd5, 6'b011110};
         "2": r = '{3'd5, 6'b001110};
         "3": r = '{3'd5, 6'b000110};
         "4": r = '{3'd5, 6'b000010};
         "5": r = '{3'd5, 6'b000000};
         "6": r = '{3'd5, 6'b100000};
         "7": r = '{3'd5, 6'b110000};
         "8": r = '{3'd5, 6'b111000};
         "9": r = '{3'd5, 6'b111100};
         ",": r = '{3'd6, 6'b110011};
         ".": r = '{3'd6, 6'b010101};
         "?": r = '{3'd6, 6'b001100};
         ";": r = '{3'd6, 6'b101010};
         ":": r = '{3'd6, 6'b111000};
         "'": r = '{3'd6, 6'b011110};
         "-": r = '{3'd6, 6'b100001};
         "/": r = '{3'd5, 6'b100100};
         "(": r = '{3'd5, 6'b101100};
         ")": r = '{3'd6, 6'b101101};
         "_": r = '{3'd6, 6'b001101};
         default: r = '{3'd0, 6'b000000};
      endcase
      return r;
   endfunction

endpackage

>>> design/morse_code_keyer.sv
// top level of the morse code keyer: csr registers, front, queue and back
//
// req side is a queue input: drive req_character and raise req_push; the
// word is taken at a clock edge where req_full is low. lower-case letters
// fold to capitals; a space or any character without a morse code gives a
// single key-off segment of word-gap length
// rsp side is a queue output: while rsp_empty is low the oldest segment
// (rsp_key_on, rsp_duration_units, rsp_last_segment) is presented, and it
// is taken at an edge where rsp_pop is high
// a coded character of n elements gives 2n segments: key-on dot or dash,
// then key-off element gap; the last gap carries the letter extra and
// rsp_last_segment
// the first segment of a word is presented after it passes the front
// register (which loads at the edge that takes the word), the queue and
// the output register. one segment per cycle while the rsp side pops, set
// by the back end's element sequencer, so a character gives 1 to 12
// segments; the queue lets the front keep taking words meanwhile
// a stalled rsp side holds the segment and fills the queue, then req_full
// rises; reset empties front, queue and output and restores the csr
// defaults. csr writes take effect at once and belong in idle periods
module morse_code_keyer #(
   parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_character,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_key_on,
   output logic [4:0] rsp_duration_units,
   output logic       rsp_last_segment,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [3:0] csr_wdata
);
   import mck_pkg::*;

   mck_cfg_type   cfg_ff, cfg_in;
   logic          cls_valid, cls_ready;
   mck_class_type cls_word;
   logic          head_valid, head_pop;
   mck_class_type head_word;

   // csr decode; indexes past the word gap register are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DOT:          cfg_in.dot          = csr_wdata;
            CSR_DASH:         cfg_in.dash         = csr_wdata;
            CSR_ELEMENT_GAP:  cfg_in.element_gap  = csr_wdata;
            CSR_LETTER_EXTRA: cfg_in.letter_extra = csr_wdata;
            CSR_WORD_GAP:     cfg_in.word_gap     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{DOT_RESET, DASH_RESET, ELEMENT_GAP_RESET,
                     LETTER_EXTRA_RESET, WORD_GAP_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: table lookup into a register stage
   mck_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_character (req_character),
      .req_full      (req_full),
      .cls_valid     (cls_valid),
      .cls_word      (cls_word),
      .cls_ready     (cls_ready)
   );

   // decoupling queue of classified characters
   mck_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cls_valid),
      .push_word  (cls_word),
      .push_ready (cls_ready),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop        (head_pop)
   );

   // back: segment sequencer with the output register
   mck_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head_valid         (head_valid),
      .head_word          (head_word),
      .head_pop           (head_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_key_on         (rsp_key_on),
      .rsp_duration_units (rsp_duration_units),
      .rsp_last_segment   (rsp_last_segment)
   );

endmodule

>>> design/mck_front.sv
// front end: takes characters and registers their classified code
module mck_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_character,
   output logic                  req_full,
   output logic                  cls_valid,
   output mck_pkg::mck_class_type cls_word,
   input  logic                  cls_ready
);
   import mck_pkg::*;

   logic          valid_ff, valid_in;
   mck_class_type word_ff, word_in;
   logic          take;

   assign take     = !valid_ff || cls_ready;
   assign req_full = !take;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (take) begin
         valid_in = req_push;
         word_in  = mck_classify(req_character);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign cls_valid = valid_ff;
   assign cls_word  = word_ff;

endmodule

>>> design/mck_queue.sv
// short queue of classified characters between front and back
module mck_queue #(
   parameter int DEPTH = mck_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mck_pkg::mck_class_type push_word,
   output logic                   push_ready,
   output logic                   head_valid,
   output mck_pkg::mck_class_type head_word,
   input  logic                   pop
);
   import mck_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mck_class_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_word  = slots_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> design/mck_back.sv
// back end: steps through a character's elements, one segment a cycle while the output register is free
module mck_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mck_pkg::mck_cfg_type   cfg,
   input  logic                   head_valid,
   input  mck_pkg::mck_class_type head_word,
   output logic                   head_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_key_on,
   output logic [4:0]             rsp_duration_units,
   output logic                   rsp_last_segment
);
   import mck_pkg::*;

   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic              gap_ff, gap_in;
   logic              out_valid_ff, out_valid_in;
   logic              key_on_ff, key_on_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic              last_ff, last_in;
   logic              out_free, emit, final_elem, seg_last;
   logic [ELEM_W-1:0] bit_sel;

   assign out_free   = !out_valid_ff || rsp_pop;
   assign emit       = head_valid && out_free;
   assign final_elem = (elem_ff == head_word.len - 1'b1);
   assign bit_sel    = ELEM_W'(PAT_W - 1) - elem_ff;
   // an uncoded character is one word gap; otherwise the last element's gap ends it
   assign seg_last   = (head_word.len == '0) || (gap_ff && final_elem);
   assign head_pop   = emit && seg_last;

   always_comb begin
      key_on_in = key_on_ff;
      dur_in    = dur_ff;
      last_in   = last_ff;
      elem_in   = elem_ff;
      gap_in    = gap_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (emit) begin
         out_valid_in = 1'b1;
         last_in      = seg_last;
         if (head_word.len == '0) begin
            key_on_in = 1'b0;
            dur_in    = {1'b0, cfg.word_gap};
         end else if (!gap_ff) begin
            key_on_in = 1'b1;
            dur_in    = head_word.dash[bit_sel] ? {1'b0, cfg.dash} : {1'b0, cfg.dot};
         end else begin
            key_on_in = 1'b0;
            dur_in    = {1'b0, cfg.element_gap}
                      + (final_elem ? {1'b0, cfg.letter_extra} : '0);
         end
         if (seg_last) begin
            elem_in = '0;
            gap_in  = 1'b0;
         end else if (gap_ff) begin
            elem_in = elem_ff + 1'b1;
            gap_in  = 1'b0;
         end else begin
            gap_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         elem_ff      <= '0;
         gap_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         elem_ff      <= elem_in;
         gap_ff       <= gap_in;
      end
      key_on_ff <= key_on_in;
      dur_ff    <= dur_in;
      last_ff   <= last_in;
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_key_on         = key_on_ff;
   assign rsp_duration_units = dur_ff;
   assign rsp_last_segment   = last_ff;

endmodule

>>> tb/tb_morse_code_keyer.sv
// testbench of the morse code keyer: a directed table, then random words under several settings
module tb_morse_code_keyer;
   timeunit 1ns;
   timeprecision 1ps;

   import mck_pkg::*;

   // cycles with no word taken on either side before the run is called hung
   localparam int WATCHDOG_LIMIT  = 2000;
   // a word's first segment passes the front register, queue and output register, so a few spare cycles
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int WORDS_PER_PHASE = 42;
   localparam int RANDOM_PHASES   = 6;
   // word index within a phase at which the sender holds off until all is drained
   localparam int PAUSE_AT        = 20;
   localparam int DIRECTED_ROWS   = 25;

   // one keying segment as it leaves the result side
   typedef struct packed {
      logic             key_on;
      logic [DUR_W-1:0] duration;
      logic             last;
   } keying_segment_type;

   // one row of the directed table; n_typed = 0 leaves the row to the predictor
   typedef struct packed {
      logic [CHAR_W-1:0]  ch;
      logic [1:0]         n_typed;
      keying_segment_type seg_a;
      keying_segment_type seg_b;
   } directed_row_type;

   // segments read straight off the reset settings
   localparam keying_segment_type NO_SEG              = '0;
   localparam keying_segment_type WORD_GAP_SEG_RESET  = '{1'b0, 5'd6, 1'b1};
   localparam keying_segment_type DOT_ON_RESET        = '{1'b1, 5'd1, 1'b0};
   localparam keying_segment_type DASH_ON_RESET       = '{1'b1, 5'd3, 1'b0};
   localparam keying_segment_type LAST_GAP_RESET      = '{1'b0, 5'd3, 1'b1};

   // every row runs under the reset settings
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{" ",   2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // space
      '{8'h00, 2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // nul has no code
      '{8'hff, 2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // top of the byte range
      '{8'h80, 2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // first code above ascii
      '{8'h7f, 2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // last ascii code
      '{8'h60, 2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // just below lower-case a
      '{"{",   2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // just above lower-case z
      '{"@",   2'd1, WORD_GAP_SEG_RESET, NO_SEG},     // just below capital a
      '{"E",   2'd2, DOT_ON_RESET,   LAST_GAP_RESET}, // single dot
      '{"e",   2'd2, DOT_ON_RESET,   LAST_GAP_RESET}, // case folding
      '{"T",   2'd2, DASH_ON_RESET,  LAST_GAP_RESET}, // single dash
      '{"a",   2'd0, NO_SEG, NO_SEG},
      '{"z",   2'd0, NO_SEG, NO_SEG},
      '{"0",   2'd0, NO_SEG, NO_SEG},
      '{",",   2'd0, NO_SEG, NO_SEG},
      '{".",   2'd0, NO_SEG, NO_SEG},
      '{"?",   2'd0, NO_SEG, NO_SEG},
      '{";",   2'd0, NO_SEG, NO_SEG},
      '{":",   2'd0, NO_SEG, NO_SEG},
      '{"'",   2'd0, NO_SEG, NO_SEG},
      '{"-",   2'd0, NO_SEG, NO_SEG},                 // six elements, not the underscore
      '{"/",   2'd0, NO_SEG, NO_SEG},
      '{"(",   2'd0, NO_SEG, NO_SEG},                 // five elements, unlike the bracket close
      '{")",   2'd0, NO_SEG, NO_SEG},
      '{"_",   2'd0, NO_SEG, NO_SEG}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic [CHAR_W-1:0]    req_character;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic                 rsp_key_on;
   logic [DUR_W-1:0]     rsp_duration_units;
   logic                 rsp_last_segment;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [UNITS_W-1:0]   csr_wdata;

   // own copy of the timing registers, kept in step with every csr write
   mck_cfg_type        keyer_cfg;
   // segments predicted for words already taken, oldest first
   keying_segment_type pending_segments[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches     = 0;
   int words_taken    = 0;
   int segments_seen  = 0;
   int settings_used  = 1;
   int drain_pauses   = 0;

   morse_code_keyer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_character      (req_character),
      .req_full           (req_full),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_key_on         (rsp_key_on),
      .rsp_duration_units (rsp_duration_units),
      .rsp_last_segment   (rsp_last_segment),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   // international morse, dots and dashes first element first; empty means no code
   function automatic string morse_pattern(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] c;
      c = ch;
      if (c >= "a" && c <= "z") begin
         c = c - 8'd32;
      end
      case (c)
         "A": return ".-";     "B": return "-...";   "C": return "-.-.";   "D": return "-..";
         "E": return ".";      "F": return "..-.";   "G": return "--.";    "H": return "....";
         "I": return "..";     "J": return ".---";   "K": return "-.-";    "L": return ".-..";
         "M": return "--";     "N": return "-.";     "O": return "---";    "P": return ".--.";
         "Q": return "--.-";   "R": return ".-.";    "S": return "...";    "T": return "-";
         "U": return "..-";    "V": return "...-";   "W": return ".--";    "X": return "-..-";
         "Y": return "-.--";   "Z": return "--..";
         "0": return "-----";  "1": return ".----";  "2": return "..---";  "3": return "...--";
         "4": return "....-";  "5": return ".....";  "6": return "-....";  "7": return "--...";
         "8": return "---..";  "9": return "----.";
         ",": return "--..--"; ".": return ".-.-.-"; "?": return "..--.."; ";": return "-.-.-.";
         ":": return "---..."; "'": return ".----."; "-": return "-....-"; "/": return "-..-.";
         "(": return "-.--.";  ")": return "-.--.-"; "_": return "..--.-";
         default: return "";
      endcase
   endfunction

   function automatic keying_segment_type make_segment(input logic on,
                                                       input logic [DUR_W-1:0] dur,
                                                       input logic last);
      keying_segment_type seg;
      seg.key_on   = on;
      seg.duration = dur;
      seg.last     = last;
      return seg;
   endfunction

   // queue up the segments one character gives under the current settings
   task automatic predict_keying(input logic [CHAR_W-1:0] ch);
      string            pat;
      logic [DUR_W-1:0] on_len;
      logic [DUR_W-1:0] gap;
      logic             last;
      pat = morse_pattern(ch);
      if (pat.len() == 0) begin
         // space or no code: one silent word gap
         pending_segments.push_back(make_segment(1'b0, {1'b0, keyer_cfg.word_gap}, 1'b1));
      end else begin
         for (int i = 0; i < pat.len(); i++) begin
            last   = (i == pat.len() - 1);
            on_len = (pat[i] == "-") ? {1'b0, keyer_cfg.dash} : {1'b0, keyer_cfg.dot};
            // the letter extra only lengthens the closing gap; 5 bits hold 15 + 15
            gap    = {1'b0, keyer_cfg.element_gap}
                   + (last ? {1'b0, keyer_cfg.letter_extra} : 5'd0);
            pending_segments.push_back(make_segment(1'b1, on_len, 1'b0));
            pending_segments.push_back(make_segment(1'b0, gap, last));
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t, segment %0d: %s got %0d want %0d",
               $realtime, segments_seen, what, got, want);
   endtask

   // offer one word, holding it until taken; push stays high for a following word
   task automatic send_word(input logic [CHAR_W-1:0] ch, input logic [1:0] n_typed,
                            input keying_segment_type seg_a, input keying_segment_type seg_b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_character <= ch;
      do @(posedge clock); while (req_full !== 1'b0);
      words_taken++;
      if (n_typed == 2'd0) begin
         predict_keying(ch);
      end else begin
         pending_segments.push_back(seg_a);
         if (n_typed == 2'd2) begin
            pending_segments.push_back(seg_b);
         end
      end
   endtask

   // stop sending, let every predicted segment out, then a few quiet cycles
   task automatic drain_and_settle();
      req_push <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one csr write; the enable is left high so back-to-back writes need no dip
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [UNITS_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DOT:          keyer_cfg.dot          = val;
         CSR_DASH:         keyer_cfg.dash         = val;
         CSR_ELEMENT_GAP:  keyer_cfg.element_gap  = val;
         CSR_LETTER_EXTRA: keyer_cfg.letter_extra = val;
         CSR_WORD_GAP:     keyer_cfg.word_gap     = val;
         default: ;        // no register there, nothing changes
      endcase
   endtask

   task automatic apply_settings(input mck_cfg_type cfg, input bit with_bad_index);
      write_register(CSR_DOT,          cfg.dot);
      write_register(CSR_DASH,         cfg.dash);
      write_register(CSR_ELEMENT_GAP,  cfg.element_gap);
      write_register(CSR_LETTER_EXTRA, cfg.letter_extra);
      write_register(CSR_WORD_GAP,     cfg.word_gap);
      if (with_bad_index) begin
         // indexes past the word gap must leave every register alone
         for (int k = 1; k <= 3; k++) begin
            write_register(CSR_WORD_GAP + 3'(k), UNITS_W'($urandom_range(15)));
         end
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // mostly coded characters in either case, the rest a space or any byte at all
   function automatic logic [CHAR_W-1:0] pick_character();
      string coded;
      coded = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789,.?;:'-/()_";
      case ($urandom_range(9))
         0, 1:    return CHAR_W'($urandom_range(255));
         2:       return " ";
         3, 4:    return CHAR_W'("a" + $urandom_range(25));
         default: return coded[$urandom_range(coded.len() - 1)];
      endcase
   endfunction

   // receiver: check the word taken at this edge, then decide whether to pop next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            segments_seen++;
            if (pending_segments.size() == 0) begin
               report_mismatch("segment with nothing pending, duration",
                               rsp_duration_units, 0);
            end else begin
               // field by field against the oldest prediction
               if (rsp_key_on !== pending_segments[0].key_on) begin
                  report_mismatch("key_on", rsp_key_on, pending_segments[0].key_on);
               end
               if (rsp_duration_units !== pending_segments[0].duration) begin
                  report_mismatch("duration_units", rsp_duration_units,
                                  pending_segments[0].duration);
               end
               if (rsp_last_segment !== pending_segments[0].last) begin
                  report_mismatch("last_segment", rsp_last_segment, pending_segments[0].last);
               end
               void'(pending_segments.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: a long run of cycles with no word taken on either side means a hang
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("watchdog: no word moved for %0d cycles, %0d segments still pending",
               WATCHDOG_LIMIT, pending_segments.size());
      $display("FAILURE");
      $finish;
   end

   // main sequence
   initial begin
      mck_cfg_type next_cfg;
      int          k;

      // everything driven from time zero
      reset         = 1'b1;
      req_push      = 1'b0;
      req_character = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_DOT;
      csr_wdata     = '0;
      keyer_cfg     = '{DOT_RESET, DASH_RESET, ELEMENT_GAP_RESET, LETTER_EXTRA_RESET,
                        WORD_GAP_RESET};
      send_idle_pct = 6;
      recv_idle_pct = 65;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under the reset settings
      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].ch, directed_rows[r].n_typed,
                   directed_rows[r].seg_a, directed_rows[r].seg_b);
      end
      drain_and_settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       next_cfg = '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15}; // longest last gap
            1:       next_cfg = '{4'd1, 4'd1, 4'd1, 4'd0, 4'd1};      // shortest in range
            2:       next_cfg = '0;                                   // zero-length segments
            5:       next_cfg = '{DOT_RESET, DASH_RESET, ELEMENT_GAP_RESET,
                                  LETTER_EXTRA_RESET, WORD_GAP_RESET};
            default: next_cfg = '{UNITS_W'($urandom_range(15)), UNITS_W'($urandom_range(15)),
                                  UNITS_W'($urandom_range(15)), UNITS_W'($urandom_range(15)),
                                  UNITS_W'($urandom_range(15))};
         endcase
         apply_settings(next_cfg, p == 4);

         for (int w = 0; w < WORDS_PER_PHASE; w++) begin
            // idle pattern by position in the random part: slow receiver, slow sender, none
            k = p * WORDS_PER_PHASE + w;
            if (k < RANDOM_PHASES * WORDS_PER_PHASE / 3) begin
               send_idle_pct = 6;
               recv_idle_pct = 65;
            end else if (k < 2 * RANDOM_PHASES * WORDS_PER_PHASE / 3) begin
               send_idle_pct = 65;
               recv_idle_pct = 6;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            send_word(pick_character(), 2'd0, NO_SEG, NO_SEG);
            if (w == PAUSE_AT) begin
               // hold the sender off until the keyer has emptied completely
               drain_and_settle();
               drain_pauses++;
            end
         end
         drain_and_settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_segments.size() != 0) begin
         report_mismatch("segments never delivered", 0, pending_segments.size());
      end

      $display("run covered %0d characters and %0d keying segments under %0d register settings",
               words_taken, segments_seen, settings_used);
      $display("with %0d full drains mid-phase and %0d mismatches", drain_pauses, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
